@@ src/prat_pkg.sv @@
// Shared types, constants and the arctangent step table for the point rotator.
// No dependencies; imported by every module of the block.
`default_nettype none

package prat_pkg;

  // Rotation axis code carried with each request
  typedef enum logic [1:0] {
    KIND_X    = 2'd0,
    KIND_Y    = 2'd1,
    KIND_Z    = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PIVOT_X = 3'd0,
    CFG_PIVOT_Y = 3'd1,
    CFG_PIVOT_Z = 3'd2,
    CFG_ANGLE_X = 3'd3,
    CFG_ANGLE_Y = 3'd4,
    CFG_ANGLE_Z = 3'd5
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned ANGLE_W      = 16;
  // CORDIC datapath: 30 fraction bits plus headroom and sign
  localparam int unsigned CORDIC_W     = 34;
  localparam int unsigned ATAN_W       = 30;
  localparam int unsigned ATAN_ENTRIES = 24;
  // Sine and cosine in 16 fraction bits, room for one and its negation
  localparam int unsigned TRIG_W       = 18;
  localparam int unsigned TRIG_SHIFT   = 14;
  localparam int unsigned FRAC_W       = 16;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] TRIG_ROUND  = 34'sd8192;
  localparam logic signed [TRIG_W-1:0]   TRIG_ONE    = 18'sd65536;
  localparam logic [ANGLE_W-1:0]         HALF_TURN   = 16'h8000;

  // Control bits that ride along with the payload
  typedef struct packed {
    kind_e kind;
    logic  flip;
  } prat_ctrl_t;

  // Angle step of CORDIC stage idx, 2^32 units per turn
  function automatic logic [ATAN_W-1:0] atan_step(input int unsigned idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      0:       val = 30'h20000000;
      1:       val = 30'h12E4051E;
      2:       val = 30'h09FB385B;
      3:       val = 30'h051111D4;
      4:       val = 30'h028B0D43;
      5:       val = 30'h0145D7E1;
      6:       val = 30'h00A2F61E;
      7:       val = 30'h00517C55;
      8:       val = 30'h0028BE53;
      9:       val = 30'h00145F2F;
      10:      val = 30'h000A2F98;
      11:      val = 30'h000517CC;
      12:      val = 30'h00028BE6;
      13:      val = 30'h000145F3;
      14:      val = 30'h0000A2FA;
      15:      val = 30'h0000517D;
      16:      val = 30'h000028BE;
      17:      val = 30'h0000145F;
      18:      val = 30'h00000A30;
      19:      val = 30'h00000518;
      20:      val = 30'h0000028C;
      21:      val = 30'h00000146;
      22:      val = 30'h000000A3;
      23:      val = 30'h00000051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

@@ src/prat_front.sv @@
// Front stage: picks the plane and angle for the axis, subtracts the pivot and
// reduces the angle to the right half turn. Depends on prat_pkg.
`default_nettype none

module prat_front #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]        point_x_i,
  input  logic signed [COORD_WIDTH-1:0]        point_y_i,
  input  logic signed [COORD_WIDTH-1:0]        point_z_i,
  input  logic [1:0]                           kind_i,
  input  logic signed [COORD_WIDTH-1:0]        pivot_x_i,
  input  logic signed [COORD_WIDTH-1:0]        pivot_y_i,
  input  logic signed [COORD_WIDTH-1:0]        pivot_z_i,
  input  logic [prat_pkg::ANGLE_W-1:0]         angle_x_i,
  input  logic [prat_pkg::ANGLE_W-1:0]         angle_y_i,
  input  logic [prat_pkg::ANGLE_W-1:0]         angle_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [COORD_WIDTH-1:0]        u_o,
  output logic signed [COORD_WIDTH-1:0]        v_o,
  output logic signed [COORD_WIDTH-1:0]        w_o,
  output logic signed [COORD_WIDTH-1:0]        piv1_o,
  output logic signed [COORD_WIDTH-1:0]        piv2_o,
  output logic signed [prat_pkg::CORDIC_W-1:0] z_o,
  output prat_pkg::prat_ctrl_t                 ctrl_o
);
  import prat_pkg::*;

  kind_e                   kind;
  logic signed [COORD_WIDTH-1:0] sel_u, sel_v, sel_w, sel_p1, sel_p2;
  logic [ANGLE_W-1:0]      angle, angle_red;
  logic [1:0]              quarter;
  logic                    flip;
  logic                    valid_q;
  logic signed [COORD_WIDTH-1:0] u_q, v_q, w_q, piv1_q, piv2_q;
  logic signed [CORDIC_W-1:0]    z_q;
  prat_ctrl_t              ctrl_q;

  assign kind = kind_e'(kind_i);

  // Select plane coordinates, pivots and angle for the axis
  always_comb begin
    unique case (kind)
      KIND_X: begin
        sel_u = point_y_i; sel_v = point_z_i; sel_w = point_x_i;
        sel_p1 = pivot_y_i; sel_p2 = pivot_z_i; angle = angle_x_i;
      end
      KIND_Y: begin
        sel_u = point_z_i; sel_v = point_x_i; sel_w = point_y_i;
        sel_p1 = pivot_z_i; sel_p2 = pivot_x_i; angle = angle_y_i;
      end
      KIND_Z: begin
        sel_u = point_x_i; sel_v = point_y_i; sel_w = point_z_i;
        sel_p1 = pivot_x_i; sel_p2 = pivot_y_i; angle = angle_z_i;
      end
      default: begin
        // unused axis: identity rotation about a zero pivot
        sel_u = point_x_i; sel_v = point_y_i; sel_w = point_z_i;
        sel_p1 = '0; sel_p2 = '0; angle = '0;
      end
    endcase
  end

  // Fold the second and third quarter turns by a half turn
  assign quarter   = angle[ANGLE_W-1 -: 2];
  assign flip      = (quarter == 2'd1) || (quarter == 2'd2);
  assign angle_red = flip ? angle - HALF_TURN : angle;

  assign in_stall_o = valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      u_q         <= sel_u - sel_p1;
      v_q         <= sel_v - sel_p2;
      w_q         <= sel_w;
      piv1_q      <= sel_p1;
      piv2_q      <= sel_p2;
      z_q         <= {{(CORDIC_W-ANGLE_W-FRAC_W){angle_red[ANGLE_W-1]}}, angle_red,
                      {FRAC_W{1'b0}}};
      ctrl_q.kind <= kind;
      ctrl_q.flip <= flip;
    end
  end

  assign out_valid_o = valid_q;
  assign u_o         = u_q;
  assign v_o         = v_q;
  assign w_o         = w_q;
  assign piv1_o      = piv1_q;
  assign piv2_o      = piv2_q;
  assign z_o         = z_q;
  assign ctrl_o      = ctrl_q;

endmodule

`default_nettype wire

@@ src/prat_cordic.sv @@
// Pipelined rotation-mode CORDIC, one registered stage per iteration, with the
// request payload carried alongside. Depends on prat_pkg.
`default_nettype none

module prat_cordic #(
  parameter int unsigned STAGES = 16,
  parameter int unsigned PW     = 160
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [prat_pkg::CORDIC_W-1:0] z_i,
  input  prat_pkg::prat_ctrl_t                 ctrl_i,
  input  logic [PW-1:0]                        data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [prat_pkg::CORDIC_W-1:0] x_o,
  output logic signed [prat_pkg::CORDIC_W-1:0] y_o,
  output prat_pkg::prat_ctrl_t                 ctrl_o,
  output logic [PW-1:0]                        data_o
);
  import prat_pkg::*;

  logic                       valid_q [STAGES];
  logic signed [CORDIC_W-1:0] x_q     [STAGES];
  logic signed [CORDIC_W-1:0] y_q     [STAGES];
  logic signed [CORDIC_W-1:0] z_q     [STAGES];
  prat_ctrl_t                 ctrl_q  [STAGES];
  logic [PW-1:0]              data_q  [STAGES];
  logic [STAGES:0]            stall;

  assign stall[STAGES] = out_stall_i;
  assign in_stall_o    = stall[0];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                       v_in;
    logic signed [CORDIC_W-1:0] x_in, y_in, z_in;
    logic signed [CORDIC_W-1:0] x_d, y_d, z_d;
    logic signed [CORDIC_W-1:0] step;
    prat_ctrl_t                 c_in;
    logic [PW-1:0]              d_in;

    if (k == 0) begin : g_first
      assign v_in = in_valid_i;
      assign x_in = CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = z_i;
      assign c_in = ctrl_i;
      assign d_in = data_i;
    end else begin : g_next
      assign v_in = valid_q[k-1];
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign z_in = z_q[k-1];
      assign c_in = ctrl_q[k-1];
      assign d_in = data_q[k-1];
    end

    assign step = $signed({{(CORDIC_W-ATAN_W){1'b0}}, atan_step(k)});

    // Rotate toward zero residual angle
    always_comb begin
      if (!z_in[CORDIC_W-1]) begin
        x_d = x_in - (y_in >>> k);
        y_d = y_in + (x_in >>> k);
        z_d = z_in - step;
      end else begin
        x_d = x_in + (y_in >>> k);
        y_d = y_in - (x_in >>> k);
        z_d = z_in + step;
      end
    end

    assign stall[k] = valid_q[k] && stall[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (!stall[k]) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!stall[k]) begin
        x_q[k]    <= x_d;
        y_q[k]    <= y_d;
        z_q[k]    <= z_d;
        ctrl_q[k] <= c_in;
        data_q[k] <= d_in;
      end
    end
  end

  assign out_valid_o = valid_q[STAGES-1];
  assign x_o         = x_q[STAGES-1];
  assign y_o         = y_q[STAGES-1];
  assign ctrl_o      = ctrl_q[STAGES-1];
  assign data_o      = data_q[STAGES-1];

endmodule

`default_nettype wire

@@ src/prat_mix.sv @@
// Back end: rounds sine and cosine, multiplies the plane coordinates, sums with
// rounding, adds the pivot back and maps to x, y, z. Depends on prat_pkg.
`default_nettype none

module prat_mix #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [prat_pkg::CORDIC_W-1:0] x_i,
  input  logic signed [prat_pkg::CORDIC_W-1:0] y_i,
  input  prat_pkg::prat_ctrl_t                 ctrl_i,
  input  logic signed [COORD_WIDTH-1:0]        u_i,
  input  logic signed [COORD_WIDTH-1:0]        v_i,
  input  logic signed [COORD_WIDTH-1:0]        w_i,
  input  logic signed [COORD_WIDTH-1:0]        piv1_i,
  input  logic signed [COORD_WIDTH-1:0]        piv2_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [COORD_WIDTH-1:0]        rot_x_o,
  output logic signed [COORD_WIDTH-1:0]        rot_y_o,
  output logic signed [COORD_WIDTH-1:0]        rot_z_o
);
  import prat_pkg::*;

  localparam int unsigned SW = COORD_WIDTH + FRAC_W;
  localparam int unsigned PROD_W = COORD_WIDTH + TRIG_W;
  localparam logic [SW-1:0] SUM_ROUND = SW'(1) << (FRAC_W - 1);

  localparam int unsigned NSTG = 4;

  logic [NSTG:0]   stall;
  logic [NSTG-1:0] valid_q;

  // trig stage
  logic signed [CORDIC_W-1:0]    xr, yr;
  logic signed [TRIG_W-1:0]      c_raw, s_raw, c_d, s_d, ns_d;
  logic signed [TRIG_W-1:0]      c_q, s_q, ns_q;
  logic signed [COORD_WIDTH-1:0] u1_q, v1_q, w1_q, p11_q, p21_q;
  kind_e                         kind1_q;
  // multiply stage
  logic signed [PROD_W-1:0]      uc, vns, us, vc;
  logic [SW-1:0]                 pa_q, pb_q, pc_q, pd_q;
  logic signed [COORD_WIDTH-1:0] w2_q, p12_q, p22_q;
  kind_e                         kind2_q;
  // sum stage
  logic [SW-1:0]                 f_q, g_q;
  logic signed [COORD_WIDTH-1:0] w3_q, p13_q, p23_q;
  kind_e                         kind3_q;
  // output stage
  logic signed [COORD_WIDTH-1:0] first, second;
  logic signed [COORD_WIDTH-1:0] rx_d, ry_d, rz_d, rx_q, ry_q, rz_q;

  assign stall[NSTG] = out_stall_i;
  for (genvar k = 0; k < NSTG; k++) begin : g_stall
    assign stall[k] = valid_q[k] && stall[k+1];
  end
  assign in_stall_o = stall[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (!stall[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (!stall[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Round CORDIC outputs to 16 fraction bits, undo the half-turn fold; KIND_NONE gives identity
  assign xr    = x_i + TRIG_ROUND;
  assign yr    = y_i + TRIG_ROUND;
  assign c_raw = xr[TRIG_SHIFT +: TRIG_W];
  assign s_raw = yr[TRIG_SHIFT +: TRIG_W];

  always_comb begin
    if (ctrl_i.kind == KIND_NONE) begin
      c_d  = TRIG_ONE;
      s_d  = '0;
      ns_d = '0;
    end else if (ctrl_i.flip) begin
      c_d  = -c_raw;
      s_d  = -s_raw;
      ns_d = s_raw;
    end else begin
      c_d  = c_raw;
      s_d  = s_raw;
      ns_d = -s_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall[0]) begin
      c_q     <= c_d;
      s_q     <= s_d;
      ns_q    <= ns_d;
      u1_q    <= u_i;
      v1_q    <= v_i;
      w1_q    <= w_i;
      p11_q   <= piv1_i;
      p21_q   <= piv2_i;
      kind1_q <= ctrl_i.kind;
    end
  end

  // Multiply plane coordinates by cosine and sine
  assign uc  = u1_q * c_q;
  assign vns = v1_q * ns_q;
  assign us  = u1_q * s_q;
  assign vc  = v1_q * c_q;

  always_ff @(posedge clk_i) begin
    if (!stall[1]) begin
      pa_q    <= uc[SW-1:0];
      pb_q    <= vns[SW-1:0];
      pc_q    <= us[SW-1:0];
      pd_q    <= vc[SW-1:0];
      w2_q    <= w1_q;
      p12_q   <= p11_q;
      p22_q   <= p21_q;
      kind2_q <= kind1_q;
    end
  end

  // Sum products with round half up
  always_ff @(posedge clk_i) begin
    if (!stall[2]) begin
      f_q     <= pa_q + pb_q + SUM_ROUND;
      g_q     <= pc_q + pd_q + SUM_ROUND;
      w3_q    <= w2_q;
      p13_q   <= p12_q;
      p23_q   <= p22_q;
      kind3_q <= kind2_q;
    end
  end

  // Add pivot back and place coordinates on their axes
  assign first  = $signed(f_q[SW-1:FRAC_W]) + p13_q;
  assign second = $signed(g_q[SW-1:FRAC_W]) + p23_q;

  always_comb begin
    case (kind3_q)
      KIND_X: begin
        rx_d = w3_q; ry_d = first; rz_d = second;
      end
      KIND_Y: begin
        rx_d = second; ry_d = w3_q; rz_d = first;
      end
      default: begin
        rx_d = first; ry_d = second; rz_d = w3_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (!stall[3]) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
      rz_q <= rz_d;
    end
  end

  assign out_valid_o = valid_q[NSTG-1];
  assign rot_x_o     = rx_q;
  assign rot_y_o     = ry_q;
  assign rot_z_o     = rz_q;

endmodule

`default_nettype wire

@@ src/point_rotate_about_axis.sv @@
// Top level of the point rotator: configuration registers, front stage,
// CORDIC pipeline and multiply/sum back end. Depends on prat_pkg and submodules.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------
//   in      | input     | in_valid_i / in_stall_o | point_x_i, point_y_i, point_z_i, kind_i
//   out     | output    | out_valid_o/out_stall_i | rotated_x_o, rotated_y_o, rotated_z_o
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One request enters per cycle while in_stall_o is low; the pipeline is one front
// stage, one CORDIC stage per iteration, then round, multiply, sum and output
// stages.
// Reset clears the valid bits and sets pivots and angles to zero.
// Each stage holds while the next is full and stalled; empty stages keep
// filling, so bubbles collapse ahead of a stalled output.
`default_nettype none

module point_rotate_about_axis #(
  parameter int unsigned COORD_WIDTH   = 32,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]  point_x_i,
  input  logic signed [COORD_WIDTH-1:0]  point_y_i,
  input  logic signed [COORD_WIDTH-1:0]  point_z_i,
  input  logic [1:0]                     kind_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [COORD_WIDTH-1:0]  rotated_x_o,
  output logic signed [COORD_WIDTH-1:0]  rotated_y_o,
  output logic signed [COORD_WIDTH-1:0]  rotated_z_o,
  input  logic                           cfg_we_i,
  input  logic [prat_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_WIDTH-1:0]         cfg_data_i
);
  import prat_pkg::*;

  localparam int unsigned PW = 5 * COORD_WIDTH;

  logic signed [COORD_WIDTH-1:0] pivot_x_q, pivot_y_q, pivot_z_q;
  logic [ANGLE_W-1:0]            angle_x_q, angle_y_q, angle_z_q;

  logic                          fr_valid, fr_stall;
  logic signed [COORD_WIDTH-1:0] fr_u, fr_v, fr_w, fr_p1, fr_p2;
  logic signed [CORDIC_W-1:0]    fr_z;
  prat_ctrl_t                    fr_ctrl;

  logic                          cd_valid, cd_stall;
  logic signed [CORDIC_W-1:0]    cd_x, cd_y;
  prat_ctrl_t                    cd_ctrl;
  logic [PW-1:0]                 cd_data;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_x_q <= '0;
      pivot_y_q <= '0;
      pivot_z_q <= '0;
      angle_x_q <= '0;
      angle_y_q <= '0;
      angle_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PIVOT_X: pivot_x_q <= cfg_data_i;
        CFG_PIVOT_Y: pivot_y_q <= cfg_data_i;
        CFG_PIVOT_Z: pivot_z_q <= cfg_data_i;
        CFG_ANGLE_X: angle_x_q <= cfg_data_i[ANGLE_W-1:0];
        CFG_ANGLE_Y: angle_y_q <= cfg_data_i[ANGLE_W-1:0];
        CFG_ANGLE_Z: angle_z_q <= cfg_data_i[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  prat_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .kind_i     (kind_i),
    .pivot_x_i  (pivot_x_q),
    .pivot_y_i  (pivot_y_q),
    .pivot_z_i  (pivot_z_q),
    .angle_x_i  (angle_x_q),
    .angle_y_i  (angle_y_q),
    .angle_z_i  (angle_z_q),
    .out_valid_o(fr_valid),
    .out_stall_i(fr_stall),
    .u_o        (fr_u),
    .v_o        (fr_v),
    .w_o        (fr_w),
    .piv1_o     (fr_p1),
    .piv2_o     (fr_p2),
    .z_o        (fr_z),
    .ctrl_o     (fr_ctrl)
  );

  prat_cordic #(
    .STAGES(CORDIC_STAGES),
    .PW    (PW)
  ) u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fr_valid),
    .in_stall_o (fr_stall),
    .z_i        (fr_z),
    .ctrl_i     (fr_ctrl),
    .data_i     ({fr_u, fr_v, fr_w, fr_p1, fr_p2}),
    .out_valid_o(cd_valid),
    .out_stall_i(cd_stall),
    .x_o        (cd_x),
    .y_o        (cd_y),
    .ctrl_o     (cd_ctrl),
    .data_o     (cd_data)
  );

  prat_mix #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_mix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cd_valid),
    .in_stall_o (cd_stall),
    .x_i        (cd_x),
    .y_i        (cd_y),
    .ctrl_i     (cd_ctrl),
    .u_i        (cd_data[4*COORD_WIDTH +: COORD_WIDTH]),
    .v_i        (cd_data[3*COORD_WIDTH +: COORD_WIDTH]),
    .w_i        (cd_data[2*COORD_WIDTH +: COORD_WIDTH]),
    .piv1_i     (cd_data[1*COORD_WIDTH +: COORD_WIDTH]),
    .piv2_i     (cd_data[0 +: COORD_WIDTH]),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .rot_x_o    (rotated_x_o),
    .rot_y_o    (rotated_y_o),
    .rot_z_o    (rotated_z_o)
  );

  // A stall at the input only ever comes from a held result at the output
  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // An empty front stage never refuses a request
  a_front_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fr_valid |-> !in_stall_o)
    else $error("input stalled with empty front stage");

  // A stalled CORDIC output keeps its request in place
  a_cordic_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cd_valid && cd_stall) |=> (cd_valid && $stable(cd_data) && $stable(cd_x)))
    else $error("CORDIC output changed while stalled");

endmodule

`default_nettype wire
